FILE: design/bst_pkg.sv
// ---------------------------------------------------------------------------
// bst_pkg
// Types and constants shared by the bencode stream tokenizer modules.
// ---------------------------------------------------------------------------
package bst_pkg;

    // Width of the nesting depth carried on every event.
    localparam int DEPTH_W = 5;

    // Magnitude accumulator ceiling and the signed 64-bit limits.
    localparam logic [63:0] ACC_CAP  = 64'h8000_0000_0000_0001;
    localparam logic [63:0] INT_HALF = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_COLON,
        CLS_MINUS,
        CLS_DICT,
        CLS_LIST,
        CLS_INT,
        CLS_END,
        CLS_OTHER
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  raw;
        byte_class_t cls;
        logic [3:0]  digit;
        logic        fin;
    } token_t;

    typedef enum logic [2:0] {
        EV_DICT   = 3'd0,
        EV_LIST   = 3'd1,
        EV_CLOSE  = 3'd2,
        EV_INT    = 3'd3,
        EV_SSTART = 3'd4,
        EV_SBYTE  = 3'd5,
        EV_ERROR  = 3'd6
    } ev_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_BYTE   = 3'd1,
        ERR_DEPTH      = 3'd2,
        ERR_UNMATCHED  = 3'd3,
        ERR_INT_SAT    = 3'd4,
        ERR_STR_LONG   = 3'd5,
        ERR_INCOMPLETE = 3'd6
    } err_code_t;

    typedef enum logic [2:0] {
        PH_VALUE,
        PH_INT_SIGN,
        PH_INT_DIGITS,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        FR_LIST,
        FR_DKEY,
        FR_DVAL
    } frame_t;

    typedef struct packed {
        ev_kind_t           kind;
        logic [63:0]        ival;
        logic [31:0]        slen;
        logic [7:0]         sbyte;
        logic               last;
        logic               key;
        logic [DEPTH_W-1:0] depth;
        err_code_t          code;
    } event_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_limit;
        logic [31:0]        string_limit;
    } cfg_t;

endpackage

FILE: design/bst_ram.sv
// ---------------------------------------------------------------------------
// bst_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module bst_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bst_front.sv
// ---------------------------------------------------------------------------
// bst_front
// Classifies each incoming byte and holds it in a short token queue.
// ---------------------------------------------------------------------------
module bst_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      data_byte,
    input  logic            final_byte,
    output logic            tok_valid,
    output bst_pkg::token_t tok,
    input  logic            tok_pop
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_DICT  = 8'h64;
    localparam logic [7:0] CH_INT   = 8'h69;
    localparam logic [7:0] CH_LIST  = 8'h6C;
    localparam logic [7:0] CH_END   = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    bst_pkg::token_t  q_reg [QDEPTH];
    logic [QAW-1:0]   wp_reg;
    logic [QAW-1:0]   wp_next;
    logic [QAW-1:0]   rp_reg;
    logic [QAW-1:0]   rp_next;
    logic [QAW:0]     cnt_reg;
    logic [QAW:0]     cnt_next;
    logic             push;
    logic [7:0]       offset;
    bst_pkg::token_t  cls_tok;

    // Byte classification.
    always_comb
    begin
        offset        = data_byte - CH_ZERO;
        cls_tok.raw   = data_byte;
        cls_tok.fin   = final_byte;
        cls_tok.digit = offset[3:0];
        if (data_byte >= CH_ZERO && data_byte <= CH_NINE)
        begin
            cls_tok.cls = bst_pkg::CLS_DIGIT;
        end
        else
        begin
            unique case (data_byte)
                CH_COLON: cls_tok.cls = bst_pkg::CLS_COLON;
                CH_MINUS: cls_tok.cls = bst_pkg::CLS_MINUS;
                CH_DICT:  cls_tok.cls = bst_pkg::CLS_DICT;
                CH_LIST:  cls_tok.cls = bst_pkg::CLS_LIST;
                CH_INT:   cls_tok.cls = bst_pkg::CLS_INT;
                CH_END:   cls_tok.cls = bst_pkg::CLS_END;
                default:  cls_tok.cls = bst_pkg::CLS_OTHER;
            endcase
        end
    end

    assign in_stall  = (cnt_reg == (QAW + 1)'(QDEPTH));
    assign push      = in_valid && !in_stall;
    assign tok_valid = (cnt_reg != '0);
    assign tok       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = tok_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (QAW + 1)'(push) - (QAW + 1)'(tok_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cls_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/bst_back.sv
// ---------------------------------------------------------------------------
// bst_back
// Parser step: phase machine, number accumulator, string counter and the
// nesting stack. Produces up to two events for each token it takes.
// ---------------------------------------------------------------------------
module bst_back #(
    parameter int MAX_DEPTH    = 16,
    parameter int LENGTH_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bst_pkg::cfg_t   cfg,
    input  logic            tok_valid,
    input  bst_pkg::token_t tok,
    output logic            tok_pop,
    input  logic            room,
    output bst_pkg::event_t ev_a,
    output bst_pkg::event_t ev_b,
    output logic [1:0]      ev_count
);

    // Depth can never pass depth_limit, which is at most 31.
    localparam int STACK_DEPTH = (MAX_DEPTH < 31) ? MAX_DEPTH : 31;
    localparam int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int RW          = (LENGTH_WIDTH < 32) ? LENGTH_WIDTH : 32;
    localparam logic [63:0] LEN_MAX =
        (LENGTH_WIDTH >= 64) ? '1 : ((64'd1 << LENGTH_WIDTH) - 64'd1);
    localparam int DW = bst_pkg::DEPTH_W;

    bst_pkg::phase_t  phase_reg;
    bst_pkg::phase_t  phase_next;
    logic [63:0]      acc_reg;
    logic [63:0]      acc_next;
    logic             neg_reg;
    logic             neg_next;
    logic             seen_reg;
    logic             seen_next;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    rem_next;
    logic [DW-1:0]    depth_reg;
    logic [DW-1:0]    depth_next;
    bst_pkg::frame_t  top_reg;
    bst_pkg::frame_t  top_next;
    logic             byp_reg;
    logic [1:0]       byp_data_reg;

    logic             fire;
    logic [67:0]      acc_prod;
    logic [63:0]      acc_sat;
    logic             is_dkey;
    logic             is_dval;
    bst_pkg::frame_t  below;
    bst_pkg::frame_t  top_base;
    logic [1:0]       ram_rdata;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [DW-1:0]    depth_dec;
    logic [DW-1:0]    depth_dec2;

    // Decoded step.
    bst_pkg::phase_t  phase_tgt;
    logic [63:0]      acc_d;
    logic             neg_d;
    logic             seen_d;
    logic [RW-1:0]    rem_d;
    logic [DW-1:0]    depth_d;
    logic             push;
    logic             pop;
    logic             vdone;
    bst_pkg::frame_t  new_frame;
    bst_pkg::err_code_t err;
    logic             clear_all;
    logic             fin_err;
    bst_pkg::event_t  ev0;
    logic             ev0_v;
    bst_pkg::event_t  ev_err;

    assign fire    = tok_valid && room;
    assign tok_pop = fire;

    assign is_dkey = (depth_reg != '0) && (top_reg == bst_pkg::FR_DKEY);
    assign is_dval = (depth_reg != '0) && (top_reg == bst_pkg::FR_DVAL);
    assign below   = bst_pkg::frame_t'(byp_reg ? byp_data_reg : ram_rdata);

    // Multiply by ten and add the digit, saturating at the accumulator cap.
    assign acc_prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {64'd0, tok.digit};
    assign acc_sat  = (acc_prod > {4'd0, bst_pkg::ACC_CAP}) ? bst_pkg::ACC_CAP
                                                          : acc_prod[63:0];

    assign depth_dec  = depth_reg - DW'(1);
    assign depth_dec2 = depth_next - DW'(2);

    // Outputs of the step: events, data path updates and stack actions.
    always_comb
    begin
        phase_tgt = phase_reg;
        acc_d     = acc_reg;
        neg_d     = neg_reg;
        seen_d    = seen_reg;
        rem_d     = rem_reg;
        depth_d   = depth_reg;
        push      = 1'b0;
        pop       = 1'b0;
        vdone     = 1'b0;
        new_frame = bst_pkg::FR_LIST;
        err       = bst_pkg::ERR_NONE;
        ev0_v     = 1'b0;
        ev0       = '0;

        unique case (phase_reg)
            bst_pkg::PH_BODY:
            begin
                ev0_v     = 1'b1;
                ev0.kind  = bst_pkg::EV_SBYTE;
                ev0.sbyte = tok.raw;
                ev0.last  = (rem_reg <= RW'(1));
                ev0.key   = is_dkey;
                rem_d     = (rem_reg != '0) ? rem_reg - RW'(1) : rem_reg;
                if (rem_reg <= RW'(1))
                begin
                    rem_d     = '0;
                    phase_tgt = bst_pkg::PH_VALUE;
                    vdone     = 1'b1;
                end
            end

            bst_pkg::PH_LEN:
            begin
                if (tok.cls == bst_pkg::CLS_DIGIT)
                begin
                    acc_d = acc_sat;
                end
                else if (tok.cls == bst_pkg::CLS_COLON)
                begin
                    acc_d = '0;
                    if (acc_reg > {32'd0, cfg.string_limit} || acc_reg > LEN_MAX)
                    begin
                        err = bst_pkg::ERR_STR_LONG;
                    end
                    else
                    begin
                        ev0_v    = 1'b1;
                        ev0.kind = bst_pkg::EV_SSTART;
                        ev0.slen = acc_reg[31:0];
                        ev0.last = (acc_reg == '0);
                        ev0.key  = is_dkey;
                        if (acc_reg == '0)
                        begin
                            phase_tgt = bst_pkg::PH_VALUE;
                            vdone     = 1'b1;
                        end
                        else
                        begin
                            rem_d     = acc_reg[RW-1:0];
                            phase_tgt = bst_pkg::PH_BODY;
                        end
                    end
                end
                else
                begin
                    err = bst_pkg::ERR_BAD_BYTE;
                end
            end

            bst_pkg::PH_INT_SIGN,
            bst_pkg::PH_INT_DIGITS:
            begin
                if (tok.cls == bst_pkg::CLS_MINUS && phase_reg == bst_pkg::PH_INT_SIGN)
                begin
                    neg_d     = 1'b1;
                    phase_tgt = bst_pkg::PH_INT_DIGITS;
                end
                else if (tok.cls == bst_pkg::CLS_DIGIT)
                begin
                    acc_d     = acc_sat;
                    seen_d    = 1'b1;
                    phase_tgt = bst_pkg::PH_INT_DIGITS;
                end
                else if (tok.cls == bst_pkg::CLS_END && seen_reg)
                begin
                    ev0_v    = 1'b1;
                    ev0.kind = bst_pkg::EV_INT;
                    if (neg_reg)
                    begin
                        if (acc_reg > bst_pkg::INT_HALF)
                        begin
                            ev0.code = bst_pkg::ERR_INT_SAT;
                        end
                        ev0.ival = (acc_reg >= bst_pkg::INT_HALF) ? bst_pkg::INT_HALF
                                                                  : (64'd0 - acc_reg);
                    end
                    else
                    begin
                        if (acc_reg > bst_pkg::INT_MAX)
                        begin
                            ev0.code = bst_pkg::ERR_INT_SAT;
                            ev0.ival = bst_pkg::INT_MAX;
                        end
                        else
                        begin
                            ev0.ival = acc_reg;
                        end
                    end
                    acc_d     = '0;
                    neg_d     = 1'b0;
                    seen_d    = 1'b0;
                    phase_tgt = bst_pkg::PH_VALUE;
                    vdone     = 1'b1;
                end
                else
                begin
                    err = bst_pkg::ERR_BAD_BYTE;
                end
            end

            default:
            begin
                phase_tgt = bst_pkg::PH_VALUE;
                if (tok.cls == bst_pkg::CLS_DIGIT)
                begin
                    acc_d     = {60'd0, tok.digit};
                    phase_tgt = bst_pkg::PH_LEN;
                end
                else if (tok.cls == bst_pkg::CLS_END)
                begin
                    if (depth_reg == '0)
                    begin
                        err = bst_pkg::ERR_UNMATCHED;
                    end
                    else if (is_dval)
                    begin
                        err = bst_pkg::ERR_BAD_BYTE;
                    end
                    else
                    begin
                        pop      = 1'b1;
                        depth_d  = depth_dec;
                        ev0_v    = 1'b1;
                        ev0.kind = bst_pkg::EV_CLOSE;
                        vdone    = 1'b1;
                    end
                end
                else if (is_dkey)
                begin
                    err = bst_pkg::ERR_BAD_BYTE;
                end
                else if (tok.cls == bst_pkg::CLS_DICT || tok.cls == bst_pkg::CLS_LIST)
                begin
                    if (depth_reg >= cfg.depth_limit || depth_reg >= DW'(STACK_DEPTH))
                    begin
                        err = bst_pkg::ERR_DEPTH;
                    end
                    else
                    begin
                        push      = 1'b1;
                        depth_d   = depth_reg + DW'(1);
                        ev0_v     = 1'b1;
                        if (tok.cls == bst_pkg::CLS_DICT)
                        begin
                            new_frame = bst_pkg::FR_DKEY;
                            ev0.kind  = bst_pkg::EV_DICT;
                        end
                        else
                        begin
                            new_frame = bst_pkg::FR_LIST;
                            ev0.kind  = bst_pkg::EV_LIST;
                        end
                    end
                end
                else if (tok.cls == bst_pkg::CLS_INT)
                begin
                    acc_d     = '0;
                    neg_d     = 1'b0;
                    seen_d    = 1'b0;
                    phase_tgt = bst_pkg::PH_INT_SIGN;
                end
                else
                begin
                    err = bst_pkg::ERR_BAD_BYTE;
                end
            end
        endcase

        ev0.depth = depth_d;

        fin_err   = (err == bst_pkg::ERR_NONE) && tok.fin
                 && (phase_tgt != bst_pkg::PH_VALUE || depth_d != '0);
        clear_all = (err != bst_pkg::ERR_NONE) || fin_err;

        ev_err      = '0;
        ev_err.kind = bst_pkg::EV_ERROR;
        ev_err.code = (err != bst_pkg::ERR_NONE) ? err : bst_pkg::ERR_INCOMPLETE;

        ev_a     = ev0;
        ev_b     = ev_err;
        ev_count = 2'd0;
        if (fire)
        begin
            if (err != bst_pkg::ERR_NONE)
            begin
                ev_a     = ev_err;
                ev_count = 2'd1;
            end
            else if (fin_err)
            begin
                if (ev0_v)
                begin
                    ev_count = 2'd2;
                end
                else
                begin
                    ev_a     = ev_err;
                    ev_count = 2'd1;
                end
            end
            else
            begin
                ev_count = {1'b0, ev0_v};
            end
        end
    end

    // Next parse phase.
    always_comb
    begin
        if (!fire)
        begin
            phase_next = phase_reg;
        end
        else if (clear_all)
        begin
            phase_next = bst_pkg::PH_VALUE;
        end
        else
        begin
            phase_next = phase_tgt;
        end
    end

    // Data registers and the cached stack top.
    always_comb
    begin
        top_base = pop ? below : top_reg;
        if (push)
        begin
            top_next = new_frame;
        end
        else if (vdone && top_base == bst_pkg::FR_DKEY)
        begin
            top_next = bst_pkg::FR_DVAL;
        end
        else if (vdone && top_base == bst_pkg::FR_DVAL)
        begin
            top_next = bst_pkg::FR_DKEY;
        end
        else
        begin
            top_next = top_base;
        end
        if (!fire)
        begin
            top_next = top_reg;
        end

        if (!fire)
        begin
            acc_next   = acc_reg;
            neg_next   = neg_reg;
            seen_next  = seen_reg;
            rem_next   = rem_reg;
            depth_next = depth_reg;
        end
        else if (clear_all)
        begin
            acc_next   = '0;
            neg_next   = 1'b0;
            seen_next  = 1'b0;
            rem_next   = '0;
            depth_next = '0;
        end
        else
        begin
            acc_next   = acc_d;
            neg_next   = neg_d;
            seen_next  = seen_d;
            rem_next   = rem_d;
            depth_next = depth_d;
        end
    end

    // The top frame lives in top_reg; the RAM holds the frames beneath it and
    // always presents the one directly below the top for a pop.
    assign ram_we    = fire && push && (depth_reg != '0);
    assign ram_waddr = depth_dec[AW-1:0];
    assign ram_raddr = (depth_next >= DW'(2)) ? depth_dec2[AW-1:0] : '0;

    bst_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        top_reg      <= top_next;
        byp_data_reg <= top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bst_pkg::PH_VALUE;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            depth_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            depth_reg <= depth_next;
            byp_reg   <= ram_we && (ram_waddr == ram_raddr);
        end
    end

endmodule

FILE: design/bst_evq.sv
// ---------------------------------------------------------------------------
// bst_evq
// Four-entry event queue that takes up to two events a cycle and hands one
// event a cycle to the output channel while out_stall is low.
// ---------------------------------------------------------------------------
module bst_evq (
    input  logic            clk,
    input  logic            rst_n,
    input  bst_pkg::event_t ev_a,
    input  bst_pkg::event_t ev_b,
    input  logic [1:0]      ev_count,
    output logic            room,
    output logic            out_valid,
    input  logic            out_stall,
    output bst_pkg::event_t head
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    bst_pkg::event_t q_reg [QDEPTH];
    logic [QAW-1:0]  wp_reg;
    logic [QAW-1:0]  wp_next;
    logic [QAW-1:0]  wp_inc;
    logic [QAW-1:0]  rp_reg;
    logic [QAW-1:0]  rp_next;
    logic [QAW:0]    cnt_reg;
    logic [QAW:0]    cnt_next;
    logic            pop;

    // Space for two more events, whatever leaves this cycle.
    assign room      = (cnt_reg <= (QAW + 1)'(QDEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = q_reg[rp_reg];
    assign wp_inc    = wp_reg + 1'b1;

    always_comb
    begin
        wp_next  = wp_reg + QAW'(ev_count);
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (QAW + 1)'(ev_count) - (QAW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (ev_count != 2'd0)
        begin
            q_reg[wp_reg] <= ev_a;
        end
        if (ev_count == 2'd2)
        begin
            q_reg[wp_inc] <= ev_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/bencode_stream_tokenizer.sv
// ---------------------------------------------------------------------------
// bencode_stream_tokenizer
// Streaming bencode tokenizer: one byte in, token events out.
// ---------------------------------------------------------------------------
// The block reads a bencoded byte stream one word (byte) at a time and
// reports token events rather than building a tree: dictionary open, list
// open, close, integer, string start with its declared length, and each
// string body byte with a last mark; string events inside a dictionary key
// carry is_dict_key. Malformed input (bad byte, nesting deeper than
// depth_limit, unmatched close, string longer than string_limit, or a
// structure left open on the word marked final_byte) produces an error event
// and the parser returns to its idle state with its accumulator, string
// counter and depth cleared. A byte yields zero, one or two events. The
// parser takes one byte per clock cycle while the event queue has room for
// two events: the parser step (phase update, one multiply-by-ten add, and a
// stack push or pop) is combinational ahead of its registers, and the frame
// below the top of the nesting stack is kept prefetched from the stack RAM so
// a close never waits on the RAM read. A four-entry byte queue feeds the
// parser and a four-entry event queue drains it, so either side may stall
// without stopping the other at once. The user makes configuration writes
// through the APB port only while no byte is in flight; no check enforces it.
// ---------------------------------------------------------------------------
module bencode_stream_tokenizer #(
    parameter int MAX_DEPTH    = 16,
    parameter int LENGTH_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,

    // Byte channel.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,

    // Event channel.
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         event_kind,
    output logic signed [63:0] integer_value,
    output logic [31:0]        string_length,
    output logic [7:0]         string_byte,
    output logic               last_string_byte,
    output logic               is_dict_key,
    output logic [4:0]         nesting_depth,
    output logic [2:0]         error_code,

    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Register indexes (byte address divided by four).
    localparam logic REG_DEPTH_LIMIT  = 1'b0;
    localparam logic REG_STRING_LIMIT = 1'b1;

    logic [bst_pkg::DEPTH_W-1:0] depth_limit_reg;
    logic [31:0]                 string_limit_reg;
    logic                        cfg_write;
    bst_pkg::cfg_t               cfg;

    logic                        tok_valid;
    bst_pkg::token_t             tok;
    logic                        tok_pop;
    logic                        room;
    bst_pkg::event_t             ev_a;
    bst_pkg::event_t             ev_b;
    logic [1:0]                  ev_count;
    bst_pkg::event_t             head;

    // Configuration registers. Writes land on the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg  <= 5'd16;
            string_limit_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_DEPTH_LIMIT)
            begin
                depth_limit_reg <= pwdata[bst_pkg::DEPTH_W-1:0];
            end
            else
            begin
                string_limit_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_STRING_LIMIT: prdata = string_limit_reg;
            default:          prdata = {27'd0, depth_limit_reg};
        endcase
    end

    assign cfg.depth_limit  = depth_limit_reg;
    assign cfg.string_limit = string_limit_reg;

    // Front: classify bytes and queue them.
    bst_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .tok_valid  (tok_valid),
        .tok        (tok),
        .tok_pop    (tok_pop)
    );

    // Back: the parser proper, one token per cycle while the event queue has
    // space for the two events a token can cause.
    bst_back #(
        .MAX_DEPTH    (MAX_DEPTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .room      (room),
        .ev_a      (ev_a),
        .ev_b      (ev_b),
        .ev_count  (ev_count)
    );

    // Event queue in front of the output channel.
    bst_evq u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_a      (ev_a),
        .ev_b      (ev_b),
        .ev_count  (ev_count),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign event_kind       = head.kind;
    assign integer_value    = $signed(head.ival);
    assign string_length    = head.slen;
    assign string_byte      = head.sbyte;
    assign last_string_byte = head.last;
    assign is_dict_key      = head.key;
    assign nesting_depth    = head.depth;
    assign error_code       = head.code;

endmodule
